// ===== sv/bakery_ticket_arbiter_core_defines.svh =====
// Assertion macros for the bakery ticket arbiter.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef BAKERY_TICKET_ARBITER_CORE_DEFINES_SVH
`define BAKERY_TICKET_ARBITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BTA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("bakery ticket arbiter check failed");
`define BTA_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("bakery ticket arbiter check failed");
`else
`define BTA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons)
`define BTA_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons)
`endif
`endif

// ===== sv/bta_pkg.sv =====
// Shared types and constants for the bakery ticket arbiter.
// Used by the controller, the datapath and the top level.
package bta_pkg;

	localparam int CLIENTS_DEF     = 16;
	localparam int TICKET_BITS_DEF = 16;

	localparam int CFG_W        = 5;
	localparam int CLIENT_W     = 4;
	localparam int OUT_TICKET_W = 16;
	localparam int STATUS_W     = 2;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic start;
		logic walk;
		logic resolve;
		logic commit;
	} bta_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} bta_sts_t;

endpackage

// ===== sv/bta_ctrl.sv =====
// Controller state machine for the bakery ticket arbiter.
// Depends on bta_pkg for the command and status structs.
module bta_ctrl
	import bta_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bta_sts_t sts,
	output bta_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_WALK    = 4'b0010,
		S_RESOLVE = 4'b0100,
		S_COMMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
				if (in_valid) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/bta_datapath.sv =====
// Datapath of the bakery ticket arbiter: ticket memory with valid bits,
// serial max and grant walk, result resolution and output register.
// Depends on bta_pkg.
module bta_datapath
	import bta_pkg::*;
#(
	parameter int CLIENTS     = CLIENTS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bta_cmd_t            cmd,
	output bta_sts_t            sts,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_mode,
	input  logic [CLIENT_W-1:0] in_client,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [23:0]         m_tdata
);

	localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int CNT_W = $clog2(CLIENTS + 1);
	localparam logic [7:0] CLIENTS8 = 8'(CLIENTS);
	localparam logic [TICKET_BITS-1:0] TOP = {TICKET_BITS{1'b1}};
	localparam logic [TICKET_BITS-1:0] ONE = TICKET_BITS'(1);

	logic [TICKET_BITS-1:0] mem [CLIENTS];
	logic [CLIENTS-1:0]     valid_q;

	logic [CFG_W-1:0]       active_q;
	logic                   mode_q;
	logic [CLIENT_W-1:0]    who_q;

	logic [CNT_W-1:0]       addr_q;
	logic                   rd_vld_s1;
	logic                   rd_ent_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [TICKET_BITS-1:0] rd_data_s1;

	logic [TICKET_BITS-1:0] max_q;
	logic                   found_q;
	logic [TICKET_BITS-1:0] best_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [TICKET_BITS-1:0] old_who_q;

	logic [STATUS_W-1:0]    status_q;
	logic [TICKET_BITS-1:0] cand_q;
	logic [TICKET_BITS-1:0] assign_q;
	logic                   wr_en_q;
	logic                   wr_set_q;

	logic                   out_valid_q;
	logic [23:0]            out_data_q;

	logic [7:0]             act8;
	logic [7:0]             cnt8;
	logic [CNT_W-1:0]       count;
	logic [7:0]             who8;
	logic                   in_range;
	logic [IDX_W-1:0]       who_idx;
	logic [IDX_W-1:0]       addr_idx;
	logic                   rd_go;
	logic [TICKET_BITS-1:0] rd_tkt;
	logic                   rd_is_who;
	logic                   dup;
	logic                   sat;
	logic [TICKET_BITS-1:0] next_tkt;
	logic                   take_who;
	logic                   g_valid;
	logic [IDX_W-1:0]       g_idx;
	logic [7:0]             g_idx8;
	logic [31:0]            tkt32;

	always_comb begin
		act8 = {3'b000, active_q};
		if (act8 < 8'd2) begin
			cnt8 = 8'd2;
		end else if (act8 > CLIENTS8) begin
			cnt8 = CLIENTS8;
		end else begin
			cnt8 = act8;
		end
	end

	assign count     = cnt8[CNT_W-1:0];
	assign who8      = {4'b0000, who_q};
	assign in_range  = who8 < cnt8;
	assign who_idx   = IDX_W'(who8);
	assign addr_idx  = addr_q[IDX_W-1:0];
	assign rd_go     = cmd.walk && (addr_q < count);
	assign rd_tkt    = rd_ent_s1 ? rd_data_s1 : '0;
	assign rd_is_who = (8'(rd_idx_s1) == who8);

	assign sts.walk_done = (addr_q == count) && !rd_vld_s1;
	assign sts.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Ticket memory and its registered read port.
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en_q && wr_set_q) begin
			mem[who_idx] <= assign_q;
		end
		if (rd_go) begin
			rd_data_s1 <= mem[addr_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && wr_en_q) begin
			valid_q[who_idx] <= wr_set_q;
		end
	end

	// Walk over the active entries: running maximum and the grant among the
	// other clients, plus the requester's own current ticket.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			who_q      <= '0;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_ent_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			max_q      <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
			old_who_q  <= '0;
		end else if (cmd.start) begin
			mode_q     <= in_mode;
			who_q      <= in_client;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			max_q      <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
			old_who_q  <= '0;
		end else if (cmd.walk) begin
			rd_vld_s1 <= rd_go;
			if (rd_go) begin
				rd_ent_s1 <= valid_q[addr_idx];
				rd_idx_s1 <= addr_idx;
				addr_q    <= addr_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (rd_tkt > max_q) begin
					max_q <= rd_tkt;
				end
				if (rd_is_who) begin
					old_who_q <= rd_tkt;
				end else if (rd_tkt != '0 && (!found_q || rd_tkt < best_q)) begin
					found_q    <= 1'b1;
					best_q     <= rd_tkt;
					best_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	assign dup      = (old_who_q != '0);
	assign sat      = (max_q == TOP);
	assign next_tkt = sat ? TOP : (max_q + ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			cand_q   <= '0;
			assign_q <= '0;
			wr_en_q  <= 1'b0;
			wr_set_q <= 1'b0;
		end else if (cmd.resolve) begin
			wr_set_q <= !mode_q;
			if (!in_range) begin
				status_q <= ST_RANGE;
				cand_q   <= '0;
				assign_q <= '0;
				wr_en_q  <= 1'b0;
			end else if (mode_q) begin
				status_q <= ST_OK;
				cand_q   <= '0;
				assign_q <= '0;
				wr_en_q  <= 1'b1;
			end else if (dup) begin
				status_q <= ST_DUPLICATE;
				cand_q   <= old_who_q;
				assign_q <= '0;
				wr_en_q  <= 1'b0;
			end else begin
				status_q <= sat ? ST_SATURATED : ST_OK;
				cand_q   <= next_tkt;
				assign_q <= next_tkt;
				wr_en_q  <= 1'b1;
			end
		end
	end

	// The requester was left out of the grant search in the walk; fold its final ticket back in.
	assign take_who = (cand_q != '0)
		&& (!found_q || cand_q < best_q || (cand_q == best_q && who_idx < best_idx_q));
	assign g_valid  = found_q || take_who;
	assign g_idx    = take_who ? who_idx : (found_q ? best_idx_q : '0);
	assign g_idx8   = 8'(g_idx);
	assign tkt32    = 32'(assign_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {1'b0, status_q, g_idx8[3:0], g_valid, tkt32[OUT_TICKET_W-1:0]};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== sv/bakery_ticket_arbiter_core.sv =====
// Bakery ticket arbiter: each item is a request or a release from one client, and
// each item yields one result with the assigned ticket, the current grant and a
// status code. The walk covers the first count entries of the ticket memory, where
// count is the effective number of active clients; it reads one entry per cycle
// through its single registered read port and finds the largest ticket and the
// grant in one pass. A new item is taken once the previous result sits in the
// output register. Tickets live in a memory whose entries carry valid bits that
// reset clears at once, so no clearing pass is needed after reset.
`include "bakery_ticket_arbiter_core_defines.svh"
module bakery_ticket_arbiter_core
	import bta_pkg::*;
#(
	parameter int CLIENTS     = CLIENTS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,  // active_clients
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,    // client[3:0], zero pad [7:4]
	input  logic [0:0]       s_tuser,    // mode[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata     // ticket[15:0], grant_valid[16],
	                                     // grant_client[20:17], status[22:21], pad[23]
);

	bta_cmd_t cmd;
	bta_sts_t sts;

	bta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bta_datapath #(
		.CLIENTS     (CLIENTS),
		.TICKET_BITS (TICKET_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_mode   (s_tuser[0]),
		.in_client (s_tdata[CLIENT_W-1:0]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	`BTA_ASSERT_NXT(a_one_item_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`BTA_ASSERT_IMP(a_commit_needs_free_output, clk, arst_n, cmd.commit, !m_tvalid || m_tready)
	`BTA_ASSERT_IMP(a_no_grant_means_client_zero, clk, arst_n, m_tvalid && !m_tdata[16], m_tdata[20:17] == 4'd0)
	`BTA_ASSERT_IMP(a_ignored_gives_no_ticket, clk, arst_n, m_tvalid && (m_tdata[22:21] == ST_DUPLICATE || m_tdata[22:21] == ST_RANGE), m_tdata[15:0] == 16'd0)

endmodule
